[rtl/core/assert_macros.svh]
// Concurrent assertion helpers, clocked on clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/kbfim_pkg.sv]
package kbfim_pkg;

    localparam int KBFIM_FIFO_DEPTH = 256;

    typedef enum logic [2:0] {
        ACT_KEY   = 3'd0,
        ACT_READ  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_STEP  = 3'd3,
        ACT_IRET  = 3'd4
    } action_t;

    localparam logic [7:0]  PORT_KBD_DATA   = 8'h60;
    localparam logic [7:0]  PORT_KBD_STATUS = 8'h64;
    localparam logic [7:0]  PORT_PIC_DATA   = 8'h21;
    localparam logic [7:0]  PORT_PIC_CMD    = 8'h20;
    localparam logic [15:0] CMD_EOI         = 16'h0020;
    localparam logic [7:0]  MASK_RESET      = 8'hFD;
    localparam logic [7:0]  KBD_LINE_BIT    = 8'h02;

endpackage

[rtl/core/keyboard_fifo_with_interrupt_mask_unit.sv]
// A request is held in the input register, and its result in the output register on m_tdata.
// Throughput: one request per cycle unless m_tready stalls the output; the FIFO head is
// prefetched from key memory into a register each cycle; pops never wait on its read port.
// Reset: rst_n is asynchronous, active low; it empties the FIFO, clears ready,
// request and in-service, and sets the mask to 0xFD. Key memory is not cleared.
`include "assert_macros.svh"

module keyboard_fifo_with_interrupt_mask_unit
    import kbfim_pkg::*;
#(
    parameter int FIFO_DEPTH = KBFIM_FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // port[7:0], data[23:8], cpu_int_enable[24], zero[31:25]
    input  logic [31:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], irq_taken[8], bad_port[9], key_dropped[10],
    // in_service_now[18:11], zero[23:19]
    output logic [23:0] m_tdata
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic             in_valid_reg;
    action_t          in_act_reg;
    logic [7:0]       in_port_reg;
    logic [15:0]      in_data_reg;
    logic             in_int_en_reg;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             ready_reg, ready_next;
    logic [7:0]       request_reg, request_next;
    logic [7:0]       service_reg, service_next;
    logic [7:0]       mask_reg, mask_next;

    logic [7:0]       key_mem [FIFO_DEPTH];
    logic [7:0]       head_reg;
    logic             mem_we;

    logic             out_valid_reg;
    logic [7:0]       out_rd_reg, rd_next;
    logic             out_irq_reg, irq_next;
    logic             out_bad_reg, bad_next;
    logic             out_drop_reg, drop_next;
    logic [7:0]       out_service_reg;

    logic             advance;
    logic             nonempty;
    logic             full;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [7:0]       request_step;

    assign advance    = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || advance;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign nonempty   = rd_ptr_reg != wr_ptr_reg;
    assign full       = wr_ptr_inc == rd_ptr_reg;
    assign request_step = nonempty ? (request_reg | KBD_LINE_BIT) : request_reg;

    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        ready_next   = ready_reg;
        request_next = request_reg;
        service_next = service_reg;
        mask_next    = mask_reg;
        mem_we       = 1'b0;
        rd_next      = '0;
        irq_next     = 1'b0;
        bad_next     = 1'b0;
        drop_next    = 1'b0;
        if (advance)
        begin
            unique case (in_act_reg)
                ACT_KEY:
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wr_ptr_inc;
                        ready_next  = 1'b1;
                    end
                end
                ACT_READ:
                begin
                    if (in_port_reg == PORT_KBD_DATA)
                    begin
                        if (nonempty)
                        begin
                            rd_next     = head_reg;
                            rd_ptr_next = rd_ptr_inc;
                        end
                        ready_next = 1'b0;
                    end
                    else if (in_port_reg == PORT_KBD_STATUS)
                    begin
                        rd_next = {7'b0, ready_reg};
                    end
                    else if (in_port_reg == PORT_PIC_DATA)
                    begin
                        rd_next = mask_reg;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                ACT_WRITE:
                begin
                    if (in_port_reg == PORT_PIC_DATA)
                    begin
                        mask_next = in_data_reg[7:0];
                    end
                    else if (in_port_reg == PORT_PIC_CMD)
                    begin
                        if (in_data_reg == CMD_EOI)
                        begin
                            service_next = '0;
                        end
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                ACT_STEP:
                begin
                    request_next = request_step;
                    if (nonempty)
                    begin
                        ready_next = 1'b1;
                    end
                    if (in_int_en_reg && ((request_step & ~mask_reg & KBD_LINE_BIT) != '0))
                    begin
                        irq_next     = 1'b1;
                        service_next = service_reg | KBD_LINE_BIT;
                        request_next = request_step & ~KBD_LINE_BIT;
                    end
                end
                ACT_IRET:
                begin
                    service_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            ready_reg     <= 1'b0;
            request_reg   <= '0;
            service_reg   <= '0;
            mask_reg      <= MASK_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            ready_reg   <= ready_next;
            request_reg <= request_next;
            service_reg <= service_next;
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_act_reg    <= action_t'(s_tuser);
            in_port_reg   <= s_tdata[7:0];
            in_data_reg   <= s_tdata[23:8];
            in_int_en_reg <= s_tdata[24];
        end
        if (advance)
        begin
            out_rd_reg      <= rd_next;
            out_irq_reg     <= irq_next;
            out_bad_reg     <= bad_next;
            out_drop_reg    <= drop_next;
            out_service_reg <= service_next;
        end
    end

    // Prefetch the head entry; forward a key written to the head slot.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_ptr_reg] <= in_data_reg[7:0];
        end
        if (mem_we && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= in_data_reg[7:0];
        end
        else
        begin
            head_reg <= key_mem[rd_ptr_next];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_service_reg, out_drop_reg, out_bad_reg, out_irq_reg,
                       out_rd_reg};

    `ASSERT_SAME(a_irq_in_service, out_valid_reg && out_irq_reg,
                 (out_service_reg & KBD_LINE_BIT) != '0, "irq taken without in-service bit")
    `ASSERT_SAME(a_bad_port_alone, out_valid_reg && out_bad_reg,
                 !out_irq_reg && !out_drop_reg && (out_rd_reg == '0),
                 "bad port result carries other flags")
    `ASSERT_NEXT(a_key_stored, advance && (in_act_reg == ACT_KEY) && !full,
                 ready_reg && (rd_ptr_reg != wr_ptr_reg), "accepted key left FIFO empty")

endmodule
